// ===== design/modular_inverse_ext_euclid_assert.svh =====
// Assertion macros used by the modular inverse top level.
`ifndef MODULAR_INVERSE_EXT_EUCLID_ASSERT_SVH
`define MODULAR_INVERSE_EXT_EUCLID_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MIE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mie assertion failed");

// Next-cycle implication, checked out of reset.
`define MIE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mie assertion failed");

`endif

// ===== design/mie_pkg.sv =====
// Package: sequencer states of the modular inverse block.
package mie_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_UPD,
    ST_RED,
    ST_FIN
  } mie_state_t;

endpackage

// ===== design/mie_if.sv =====
// Interfaces: request and result channels of the modular inverse block.
interface mie_in_if #(
  parameter int WIDTH = 31
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] value;
  logic [WIDTH-1:0] modulus;

  modport source (output valid, value, modulus, input ready);
  modport sink   (input valid, value, modulus, output ready);
endinterface

interface mie_out_if #(
  parameter int WIDTH = 31
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] inverse;
  logic             coprime;

  modport source (output valid, inverse, coprime, input ready);
  modport sink   (input valid, inverse, coprime, output ready);
endinterface

// ===== design/mie_div_unit.sv =====
// Bit-serial divider that also accumulates quotient times a multiplier.
module mie_div_unit #(
  parameter int WIDTH = 31
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  input  logic [WIDTH-1:0] mult,
  output logic             done,
  output logic [WIDTH-1:0] remainder,
  output logic [WIDTH-1:0] quot_mul
);

  localparam int CW = $clog2(WIDTH);

  logic [WIDTH-1:0] dvd_r, dvd_nxt;
  logic [WIDTH-1:0] rem_r, rem_nxt;
  logic [WIDTH-1:0] acc_r, acc_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;
  logic             ge;
  logic [WIDTH:0]   acc_sh;
  logic [WIDTH:0]   acc_add;

  // one restoring step: shift in the next dividend bit, trial subtract
  assign trial   = {rem_r, dvd_r[WIDTH-1]};
  assign diff    = trial - {1'b0, divisor};
  assign ge      = ~diff[WIDTH];
  assign acc_sh  = {acc_r, 1'b0};
  assign acc_add = acc_sh + {1'b0, mult};

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      acc_nxt  = '0;
      cnt_nxt  = CW'(WIDTH - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[WIDTH-2:0], 1'b0};
      rem_nxt = ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
      // partial products stay below the final coefficient, so the top bit drops
      acc_nxt = ge ? acc_add[WIDTH-1:0] : acc_sh[WIDTH-1:0];
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    acc_r <= acc_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;
  assign quot_mul  = acc_r;

endmodule

// ===== design/modular_inverse_ext_euclid.sv =====
// Top level: modular inverse by the extended Euclidean algorithm.
//
//   channel  | dir | handshake             | payload
//   ---------+-----+-----------------------+------------------------------
//   in_ch    | in  | valid/ready, request  | value, modulus (WIDTH each)
//   out_ch   | out | valid/ready, result   | inverse (WIDTH), coprime (1)
//
// Each Euclid round launches the divider in ST_START, runs WIDTH bit-serial
// divide steps while the sequencer waits in ST_DIV for done, then rotates
// the remainders and coefficients in ST_UPD.
// The time a request takes grows with the number of Euclid rounds it needs.
// in_ch.ready is high only while the sequencer is idle; a finished result
// waits in the output register while the next request is taken.
// Reset is synchronous, active low, and clears the sequencer and out valid.
`include "modular_inverse_ext_euclid_assert.svh"

module modular_inverse_ext_euclid #(
  parameter int WIDTH = 31
) (
  input  logic   clk,
  input  logic   rst_n,
  mie_in_if.sink   in_ch,
  mie_out_if.source out_ch
);

  mie_pkg::mie_state_t state_r, state_nxt;

  // Euclid working set: remainders a, b, modulus, coefficient magnitudes
  logic [WIDTH-1:0] a_r, a_nxt;
  logic [WIDTH-1:0] b_r, b_nxt;
  logic [WIDTH-1:0] m_r, m_nxt;
  logic [WIDTH-1:0] c0_r, c0_nxt;
  logic [WIDTH-1:0] c1_r, c1_nxt;
  logic             neg_r, neg_nxt;

  logic [WIDTH-1:0] inv_r, inv_nxt;
  logic             cop_r, cop_nxt;
  logic             ovalid_r, ovalid_nxt;

  logic             in_acc;
  logic             div_start;
  logic             div_done;
  logic [WIDTH-1:0] div_rem;
  logic [WIDTH-1:0] div_qm;
  logic             load_out;
  logic [WIDTH:0]   c_sum;
  logic [WIDTH:0]   c_red;
  logic [WIDTH-1:0] m_minus;

  assign in_acc = in_ch.valid && in_ch.ready;

  // Shared divider: a / b, accumulating quotient * c1 bit by bit
  mie_div_unit #(
    .WIDTH (WIDTH)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (a_r),
    .divisor   (b_r),
    .mult      (c1_r),
    .done      (div_done),
    .remainder (div_rem),
    .quot_mul  (div_qm)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mie_pkg::ST_IDLE: begin
        if (in_acc) begin
          // zero modulus runs no round
          state_nxt = (in_ch.modulus == '0) ? mie_pkg::ST_RED : mie_pkg::ST_START;
        end
      end
      mie_pkg::ST_START: state_nxt = mie_pkg::ST_DIV;
      mie_pkg::ST_DIV: begin
        if (div_done) state_nxt = mie_pkg::ST_UPD;
      end
      mie_pkg::ST_UPD: begin
        state_nxt = (div_rem == '0) ? mie_pkg::ST_RED : mie_pkg::ST_START;
      end
      mie_pkg::ST_RED: state_nxt = mie_pkg::ST_FIN;
      mie_pkg::ST_FIN: begin
        if (!ovalid_r || out_ch.ready) state_nxt = mie_pkg::ST_IDLE;
      end
      default: state_nxt = mie_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ch.ready = 1'b0;
    div_start   = 1'b0;
    load_out    = 1'b0;
    case (state_r)
      mie_pkg::ST_IDLE:  in_ch.ready = 1'b1;
      mie_pkg::ST_START: div_start   = 1'b1;
      mie_pkg::ST_FIN:   load_out    = !ovalid_r || out_ch.ready;
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end

  assign c_sum   = {1'b0, c0_r} + {1'b0, div_qm};
  assign c_red   = {1'b0, c0_r} - {1'b0, m_r};
  assign m_minus = m_r - c0_r;

  // Datapath
  always_comb begin
    a_nxt   = a_r;
    b_nxt   = b_r;
    m_nxt   = m_r;
    c0_nxt  = c0_r;
    c1_nxt  = c1_r;
    neg_nxt = neg_r;
    inv_nxt = inv_r;
    cop_nxt = cop_r;
    ovalid_nxt = ovalid_r && !out_ch.ready;
    if (in_acc) begin
      a_nxt   = in_ch.value;
      b_nxt   = in_ch.modulus;
      m_nxt   = in_ch.modulus;
      // zero modulus: clear the coefficient so the reduction gives zero
      c0_nxt  = (in_ch.modulus == '0) ? '0 : WIDTH'(1);
      c1_nxt  = '0;
      neg_nxt = 1'b0;
    end
    if (state_r == mie_pkg::ST_UPD) begin
      // rotate: (a, b) <- (b, a mod b); (c0, c1) <- (c1, c0 + q*c1)
      a_nxt   = b_r;
      b_nxt   = div_rem;
      c0_nxt  = c1_r;
      c1_nxt  = c_sum[WIDTH-1:0];
      neg_nxt = !neg_r;
    end
    if (state_r == mie_pkg::ST_RED) begin
      // magnitude never exceeds the modulus: one conditional subtract
      if (!c_red[WIDTH]) c0_nxt = c_red[WIDTH-1:0];
    end
    if (load_out) begin
      inv_nxt    = (neg_r && c0_r != '0) ? m_minus : c0_r;
      cop_nxt    = (a_r == WIDTH'(1));
      ovalid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= mie_pkg::ST_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    m_r   <= m_nxt;
    c0_r  <= c0_nxt;
    c1_r  <= c1_nxt;
    neg_r <= neg_nxt;
    inv_r <= inv_nxt;
    cop_r <= cop_nxt;
  end

  assign out_ch.valid   = ovalid_r;
  assign out_ch.inverse = inv_r;
  assign out_ch.coprime = cop_r;

  // an accepted request makes the block busy on the next cycle
  `MIE_ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_acc, !in_ch.ready)
  // the divider never runs against a zero divisor
  `MIE_ASSERT_NOW(a_div_nonzero, clk, rst_n, state_r == mie_pkg::ST_DIV, b_r != '0)
  // the update step follows only a finished division
  `MIE_ASSERT_NOW(a_upd_after_done, clk, rst_n, state_r == mie_pkg::ST_UPD, $past(div_done))
  // a new result appears only out of the final state
  `MIE_ASSERT_NOW(a_out_from_fin, clk, rst_n, $rose(ovalid_r), $past(state_r) == mie_pkg::ST_FIN)

endmodule
